>>> hdl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the frustum sphere cull block
// Plane register packing, plane codes and the status that moves down the chain.
// ----------------------------------------------------------------------------
package fsc_pkg;

   localparam int NUM_PLANES = 6;
   localparam int NORM_W     = 12;  // normal component, signed Q1.10
   localparam int FRAC_BITS  = 10;
   localparam int OFFSET_LSB = 3 * NORM_W;
   localparam int IDX_W      = 3;
   localparam int RSP_W      = 8;   // inside_res + reject_plane, padded to a byte

   typedef logic [IDX_W-1:0] plane_idx_type;

   // Register indexes; the same code reports the rejecting plane.
   localparam plane_idx_type PLANE_TOP    = 3'd0;
   localparam plane_idx_type PLANE_BOTTOM = 3'd1;
   localparam plane_idx_type PLANE_LEFT   = 3'd2;
   localparam plane_idx_type PLANE_RIGHT  = 3'd3;
   localparam plane_idx_type PLANE_NEAR   = 3'd4;
   localparam plane_idx_type PLANE_FAR    = 3'd5;

   localparam plane_idx_type PLANE_ORDER [NUM_PLANES] = '{
      PLANE_TOP, PLANE_BOTTOM, PLANE_LEFT, PLANE_RIGHT, PLANE_NEAR, PLANE_FAR
   };

   // Verdict so far: rejected flag and first rejecting plane (zero while clear).
   typedef struct packed {
      logic          rej;
      plane_idx_type plane;
   } status_type;

endpackage

>>> hdl/fsc_cell.sv
// ----------------------------------------------------------------------------
// fsc_cell: one plane test of the culling chain
// Holds one plane register; multiplies in the first stage, sums and compares
// in the second, and hands the sphere and its status to the next cell.
// ----------------------------------------------------------------------------
module fsc_cell #(
   parameter int                     COORD_WIDTH = 16,
   parameter logic [2:0]             PLANE_IDX   = 3'd0
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_valid,
   input  fsc_pkg::plane_idx_type                   csr_index,
   input  logic [3*fsc_pkg::NORM_W+COORD_WIDTH-1:0] csr_data,
   input  logic                                     up_valid,
   output logic                                     up_ready,
   input  logic [COORD_WIDTH-1:0]                   up_cx,
   input  logic [COORD_WIDTH-1:0]                   up_cy,
   input  logic [COORD_WIDTH-1:0]                   up_cz,
   input  logic [COORD_WIDTH-2:0]                   up_r,
   input  fsc_pkg::status_type                      up_status,
   output logic                                     dn_valid,
   input  logic                                     dn_ready,
   output logic [COORD_WIDTH-1:0]                   dn_cx,
   output logic [COORD_WIDTH-1:0]                   dn_cy,
   output logic [COORD_WIDTH-1:0]                   dn_cz,
   output logic [COORD_WIDTH-2:0]                   dn_r,
   output fsc_pkg::status_type                      dn_status
);
   import fsc_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int PLN_W  = OFFSET_LSB + CW;
   localparam int PROD_W = CW + NORM_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int DR_W   = CW + 1;

   logic [PLN_W-1:0] plane_ff;

   // stage A: products
   logic                     a_valid_ff;
   logic [CW-1:0]            a_cx_ff, a_cy_ff, a_cz_ff;
   logic [CW-2:0]            a_r_ff;
   status_type               a_status_ff;
   logic signed [PROD_W-1:0] a_px_ff, a_py_ff, a_pz_ff, a_px_in, a_py_in, a_pz_in;
   logic signed [DR_W-1:0]   a_dr_ff, a_dr_in;
   logic                     a_ready;

   // stage B: verdict
   logic                     b_valid_ff;
   logic [CW-1:0]            b_cx_ff, b_cy_ff, b_cz_ff;
   logic [CW-2:0]            b_r_ff;
   status_type               b_status_ff, b_status_in;

   logic signed [NORM_W-1:0] nx, ny, nz;
   logic signed [CW-1:0]     off_d;
   logic signed [SUM_W-1:0]  dot_sum, bound;

   assign nx    = plane_ff[NORM_W-1:0];
   assign ny    = plane_ff[2*NORM_W-1:NORM_W];
   assign nz    = plane_ff[3*NORM_W-1:2*NORM_W];
   assign off_d = plane_ff[PLN_W-1:OFFSET_LSB];

   assign a_ready  = !b_valid_ff || dn_ready;
   assign up_ready = !a_valid_ff || a_ready;

   always_comb begin
      a_px_in = nx * $signed(up_cx);
      a_py_in = ny * $signed(up_cy);
      a_pz_in = nz * $signed(up_cz);
      // d - r, later scaled to the Q.10 grid of the dot product
      a_dr_in = $signed({off_d[CW-1], off_d}) - $signed({2'b00, up_r});
   end

   always_comb begin
      dot_sum = SUM_W'(a_px_ff) + SUM_W'(a_py_ff) + SUM_W'(a_pz_ff);
      bound   = {{(SUM_W-DR_W-FRAC_BITS){a_dr_ff[DR_W-1]}}, a_dr_ff, {FRAC_BITS{1'b0}}};
      b_status_in = a_status_ff;
      if (!a_status_ff.rej && (dot_sum < bound)) begin
         b_status_in.rej   = 1'b1;
         b_status_in.plane = PLANE_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == PLANE_IDX)) begin
            plane_ff <= csr_data;
         end
         if (up_ready) begin
            a_valid_ff <= up_valid;
         end
         if (a_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         a_cx_ff     <= up_cx;
         a_cy_ff     <= up_cy;
         a_cz_ff     <= up_cz;
         a_r_ff      <= up_r;
         a_status_ff <= up_status;
         a_px_ff     <= a_px_in;
         a_py_ff     <= a_py_in;
         a_pz_ff     <= a_pz_in;
         a_dr_ff     <= a_dr_in;
      end
      if (a_valid_ff && a_ready) begin
         b_cx_ff     <= a_cx_ff;
         b_cy_ff     <= a_cy_ff;
         b_cz_ff     <= a_cz_ff;
         b_r_ff      <= a_r_ff;
         b_status_ff <= b_status_in;
      end
   end

   assign dn_valid  = b_valid_ff;
   assign dn_cx     = b_cx_ff;
   assign dn_cy     = b_cy_ff;
   assign dn_cz     = b_cz_ff;
   assign dn_r      = b_r_ff;
   assign dn_status = b_status_ff;

   a_clear_plane_zero: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_status_ff.rej |-> b_status_ff.plane == '0)
      else $error("clear verdict carries a plane code");

   a_reject_upstream: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_status_ff.rej |-> b_status_ff.plane <= PLANE_IDX)
      else $error("rejecting plane lies beyond this cell");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !up_ready |-> a_valid_ff && b_valid_ff)
      else $error("cell stalls with an empty stage");

endmodule

>>> hdl/frustum_sphere_cull.sv
// ----------------------------------------------------------------------------
// frustum_sphere_cull: six-plane sphere culling, one sphere per clock
// A sphere is rejected by the first plane (top, bottom, left, right, near,
// far) where n.c - d < -r, computed exactly in Q.10 fixed point.
// ----------------------------------------------------------------------------
//
//  channel  direction  beat carries
//  -------  ---------  ----------------------------------------------------
//  req_     in         center_x, center_y, center_z, radius
//  rsp_     out        inside_res, reject_plane
//  csr_     in         plane register index and value (top..far = 0..5)
//
//  Accepts one beat per cycle while req_tready is high; each beat passes through
//  six cells, each a multiply stage and a sum-and-compare stage.
//  Reset clears all six planes to zero (no sphere is rejected) and empties
//  the chain. Under output back-pressure the chain keeps taking beats until
//  every stage is full; req_tready then drops. Write planes only while idle.
//
module frustum_sphere_cull #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // center_x, center_y, center_z, radius (low to high), zero padded
   input  logic [((4*COORD_WIDTH-1+7)/8)*8-1:0]     req_tdata,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // inside_res, reject_plane (low to high), zero padded
   output logic [fsc_pkg::RSP_W-1:0]                rsp_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  fsc_pkg::plane_idx_type                   csr_index,
   input  logic [3*fsc_pkg::NORM_W+COORD_WIDTH-1:0] csr_data
);
   import fsc_pkg::*;

   localparam int CW = COORD_WIDTH;

   // links between cells; link 0 is the input, link NUM_PLANES the output
   logic          lk_valid  [NUM_PLANES+1];
   logic          lk_ready  [NUM_PLANES+1];
   logic [CW-1:0] lk_cx     [NUM_PLANES+1];
   logic [CW-1:0] lk_cy     [NUM_PLANES+1];
   logic [CW-1:0] lk_cz     [NUM_PLANES+1];
   logic [CW-2:0] lk_r      [NUM_PLANES+1];
   status_type    lk_status [NUM_PLANES+1];

   // config writes land at once; indexes past the far plane match no cell
   assign csr_ready = 1'b1;

   // unpack the request beat and start with a clear verdict
   assign lk_valid[0]  = req_tvalid;
   assign req_tready   = lk_ready[0];
   assign lk_cx[0]     = req_tdata[CW-1:0];
   assign lk_cy[0]     = req_tdata[2*CW-1:CW];
   assign lk_cz[0]     = req_tdata[3*CW-1:2*CW];
   assign lk_r[0]      = req_tdata[4*CW-2:3*CW];
   assign lk_status[0] = '0;

   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
      fsc_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .PLANE_IDX   (PLANE_ORDER[g])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr_valid (csr_valid),
         .csr_index (csr_index),
         .csr_data  (csr_data),
         .up_valid  (lk_valid[g]),
         .up_ready  (lk_ready[g]),
         .up_cx     (lk_cx[g]),
         .up_cy     (lk_cy[g]),
         .up_cz     (lk_cz[g]),
         .up_r      (lk_r[g]),
         .up_status (lk_status[g]),
         .dn_valid  (lk_valid[g+1]),
         .dn_ready  (lk_ready[g+1]),
         .dn_cx     (lk_cx[g+1]),
         .dn_cy     (lk_cy[g+1]),
         .dn_cz     (lk_cz[g+1]),
         .dn_r      (lk_r[g+1]),
         .dn_status (lk_status[g+1])
      );
   end

   // the last cell's output stage is the result register
   assign rsp_tvalid           = lk_valid[NUM_PLANES];
   assign lk_ready[NUM_PLANES] = rsp_tready;
   assign rsp_tdata = {{(RSP_W-1-IDX_W){1'b0}},
                       lk_status[NUM_PLANES].plane,
                       !lk_status[NUM_PLANES].rej};

   a_inside_plane_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[IDX_W:1] == PLANE_TOP)
      else $error("inside result with a nonzero plane");

   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[IDX_W:1] <= PLANE_FAR)
      else $error("reject plane out of range");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

endmodule
